[design/chained_hash_map_macros.svh]
// Assertion macros shared by the chained hash map RTL
`ifndef CHAINED_HASH_MAP_MACROS_SVH
`define CHAINED_HASH_MAP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CHM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define CHM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/chm_pkg.sv]
// Types and constants of the chained hash map
`timescale 1ns / 1ps
`default_nettype none

package chm_pkg;

  localparam int CHM_BUCKETS = 1024;
  localparam int CHM_NODES   = 256;
  localparam int KEY_W       = 22;
  localparam int VAL_W       = 16;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_FIND   = 2'd1,
    FN_REMOVE = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RS_OK   = 2'd0,
    RS_MISS = 2'd1,
    RS_FULL = 2'd2
  } rstat_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_WALK,
    S_CLEAR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic   load_in;
    logic   walk_start;
    logic   walk_next;
    logic   ins;
    logic   rm;
    logic   clr_step;
    logic   res_we;
    logic   res_hit;
    rstat_t res_code;
    logic   out_load;
  } chm_cmd_t;

  typedef struct packed {
    logic  hash_done;
    func_t func;
    logic  pool_full;
    logic  head_valid;
    logic  key_match;
    logic  next_valid;
    logic  clr_last;
    logic  out_free;
  } chm_stat_t;

endpackage

`default_nettype wire

[design/chm_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/chm_ctrl.sv]
// Controller state machine of the chained hash map
`timescale 1ns / 1ps
`default_nettype none

module chm_ctrl import chm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire chm_stat_t st,
  output chm_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:  if (st.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_HASH;
      S_HASH: begin
        if (st.func == FN_CLEAR) state_nxt = S_CLEAR;
        else if (st.hash_done) state_nxt = S_HEAD;
      end
      S_HEAD: begin
        unique case (st.func) inside
          FN_INSERT: state_nxt = S_OUT;
          FN_FIND, FN_REMOVE: state_nxt = st.head_valid ? S_WALK : S_OUT;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_WALK:  if (st.key_match || !st.next_valid) state_nxt = S_OUT;
      S_CLEAR: if (st.clr_last) state_nxt = S_OUT;
      S_OUT:   if (st.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.res_code = RS_OK;
    in_ready = 1'b0;
    unique case (state_r)
      S_INIT: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_HASH: ;
      S_HEAD: begin
        unique case (st.func) inside
          FN_INSERT: begin
            cmd.res_we = 1'b1;
            if (st.pool_full) cmd.res_code = RS_FULL;
            else cmd.ins = 1'b1;
          end
          FN_FIND, FN_REMOVE: begin
            if (st.head_valid) begin
              cmd.walk_start = 1'b1;
            end else begin
              cmd.res_we   = 1'b1;
              cmd.res_code = RS_MISS;
            end
          end
          default: ;
        endcase
      end
      S_WALK: begin
        if (st.key_match) begin
          cmd.res_we  = 1'b1;
          cmd.res_hit = 1'b1;
          cmd.rm      = (st.func == FN_REMOVE);
        end else if (st.next_valid) begin
          cmd.walk_next = 1'b1;
        end else begin
          cmd.res_we   = 1'b1;
          cmd.res_code = RS_MISS;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.res_we   = st.clr_last;
      end
      S_OUT: cmd.out_load = st.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[design/chm_dp.sv]
// Datapath of the chained hash map: hashing, stores, chain walk, result
`timescale 1ns / 1ps
`default_nettype none

`include "chained_hash_map_macros.svh"

module chm_dp import chm_pkg::*; #(
  parameter int BUCKETS = CHM_BUCKETS,
  parameter int NODES   = CHM_NODES
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       in_func,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [VAL_W-1:0] in_value,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic                  out_found,
  output logic      [VAL_W-1:0] out_found_value,
  output logic      [1:0]       out_status,
  input  wire chm_cmd_t         cmd,
  output chm_stat_t             st
);

  localparam int  BA_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int  IX_W = $clog2(NODES);
  localparam int  CN_W = $clog2(NODES + 1);
  localparam int  NW   = KEY_W + VAL_W + 1 + IX_W;
  localparam int  BW   = IX_W + 1;
  localparam bit  POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  func_t             func_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;
  logic [BA_W-1:0]   bidx;
  logic              hash_done;

  logic [IX_W-1:0]   cur_r, prev_r;
  logic [KEY_W-1:0]  prev_key_r;
  logic [VAL_W-1:0]  prev_val_r;
  logic              has_prev_r;
  logic [CN_W-1:0]   alloc_r, alloc_nxt, sp_r, sp_nxt;
  logic [BA_W-1:0]   clr_r, clr_nxt;
  logic              res_found_r;
  logic [VAL_W-1:0]  res_val_r;
  rstat_t            res_st_r;
  logic              out_valid_r;
  logic              out_found_r;
  logic [VAL_W-1:0]  out_val_r;
  rstat_t            out_st_r;

  // stores
  logic              bk_we;
  logic [BA_W-1:0]   bk_wa;
  logic [BW-1:0]     bk_wd, bk_rd;
  logic              nd_we;
  logic [IX_W-1:0]   nd_wa, nd_ra;
  logic [NW-1:0]     nd_wd, nd_rd;
  logic [IX_W-1:0]   fs_rd;

  logic              bk_v;
  logic [IX_W-1:0]   bk_idx;
  logic [KEY_W-1:0]  nd_key;
  logic [VAL_W-1:0]  nd_val;
  logic              nd_nv;
  logic [IX_W-1:0]   nd_next;
  logic [IX_W-1:0]   new_node;
  logic              pool_full;

  // bucket index: mask for power-of-two counts, else a registered reciprocal multiply
  // and a registered multiply-subtract remainder
  if (POW2) begin : g_mask
    if (BUCKETS == 1) begin : g_one
      assign bidx = '0;
    end else begin : g_bits
      assign bidx = key_r[BA_W-1:0];
    end
    assign hash_done = 1'b1;
  end else begin : g_recip
    localparam int SH   = KEY_W + BA_W;
    localparam int RC_W = KEY_W + 1;
    localparam logic [63:0] RECIP =
      ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [RC_W-1:0] RECIP_N = RECIP[RC_W-1:0];

    logic [KEY_W+RC_W-1:0] prod_r;
    logic [KEY_W-1:0]      quo, qb, rem_full;
    logic [BA_W-1:0]       rem_r, rem_nxt;
    logic [1:0]            hc_r, hc_nxt;

    assign quo      = KEY_W'(prod_r >> SH);
    assign qb       = KEY_W'(quo * KEY_W'(BUCKETS));
    assign rem_full = key_r - qb;

    always_comb begin
      hc_nxt = hc_r;
      if (cmd.load_in) begin
        hc_nxt = 2'd2;
      end else if (hc_r != '0) begin
        hc_nxt = hc_r - 1'b1;
      end
      if (rem_full >= KEY_W'(BUCKETS)) begin
        rem_nxt = BA_W'(rem_full - KEY_W'(BUCKETS));
      end else begin
        rem_nxt = BA_W'(rem_full);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hc_r <= '0;
      end else begin
        hc_r <= hc_nxt;
      end
    end

    always_ff @(posedge clk) begin
      prod_r <= key_r * RECIP_N;
      rem_r  <= rem_nxt;
    end

    assign bidx      = rem_r;
    assign hash_done = (hc_r == '0);
  end

  assign bk_v    = bk_rd[IX_W];
  assign bk_idx  = bk_rd[IX_W-1:0];
  assign nd_key  = nd_rd[NW-1 -: KEY_W];
  assign nd_val  = nd_rd[IX_W+1 +: VAL_W];
  assign nd_nv   = nd_rd[IX_W];
  assign nd_next = nd_rd[IX_W-1:0];

  assign pool_full = (sp_r == '0) && (alloc_r == CN_W'(NODES));
  assign new_node  = (sp_r != '0) ? fs_rd : alloc_r[IX_W-1:0];
  assign nd_ra     = cmd.walk_next ? nd_next : bk_idx;

  always_comb begin
    bk_we = cmd.ins || (cmd.rm && !has_prev_r) || cmd.clr_step;
    bk_wa = cmd.clr_step ? clr_r : bidx;
    if (cmd.ins) bk_wd = {1'b1, new_node};
    else if (cmd.rm) bk_wd = {nd_nv, nd_next};
    else bk_wd = '0;

    nd_we = cmd.ins || (cmd.rm && has_prev_r);
    nd_wa = cmd.ins ? new_node : prev_r;
    nd_wd = cmd.ins ? {key_r, val_r, bk_v, bk_idx}
                    : {prev_key_r, prev_val_r, nd_nv, nd_next};
  end

  chm_ram #(.WIDTH(BW), .DEPTH(BUCKETS)) u_bucket (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_wa),
    .wdata (bk_wd),
    .raddr (bidx),
    .rdata (bk_rd)
  );

  chm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_wa),
    .wdata (nd_wd),
    .raddr (nd_ra),
    .rdata (nd_rd)
  );

  chm_ram #(.WIDTH(IX_W), .DEPTH(NODES)) u_free (
    .clk   (clk),
    .we    (cmd.rm),
    .waddr (sp_r[IX_W-1:0]),
    .wdata (cur_r),
    .raddr (IX_W'(sp_r - 1'b1)),
    .rdata (fs_rd)
  );

  always_comb begin
    alloc_nxt = alloc_r;
    sp_nxt    = sp_r;
    clr_nxt   = clr_r;
    if (cmd.clr_step) begin
      alloc_nxt = '0;
      sp_nxt    = '0;
      clr_nxt   = st.clr_last ? '0 : clr_r + 1'b1;
    end else if (cmd.ins) begin
      if (sp_r != '0) sp_nxt = sp_r - 1'b1;
      else alloc_nxt = alloc_r + 1'b1;
    end else if (cmd.rm) begin
      sp_nxt = sp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r     <= '0;
      sp_r        <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      alloc_r <= alloc_nxt;
      sp_r    <= sp_nxt;
      clr_r   <= clr_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= func_t'(in_func);
      key_r  <= in_key;
      val_r  <= in_value;
    end
    if (cmd.walk_start) begin
      cur_r      <= bk_idx;
      has_prev_r <= 1'b0;
    end else if (cmd.walk_next) begin
      prev_r     <= cur_r;
      prev_key_r <= nd_key;
      prev_val_r <= nd_val;
      has_prev_r <= 1'b1;
      cur_r      <= nd_next;
    end
    if (cmd.res_we) begin
      res_found_r <= cmd.res_hit;
      res_val_r   <= cmd.res_hit ? nd_val : '0;
      res_st_r    <= cmd.res_code;
    end
    if (cmd.out_load) begin
      out_found_r <= res_found_r;
      out_val_r   <= res_val_r;
      out_st_r    <= res_st_r;
    end
  end

  always_comb begin
    st.hash_done  = hash_done;
    st.func       = func_r;
    st.pool_full  = pool_full;
    st.head_valid = bk_v;
    st.key_match  = (nd_key == key_r);
    st.next_valid = nd_nv;
    st.clr_last   = (clr_r == BA_W'(BUCKETS - 1));
    st.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_found_value = out_val_r;
  assign out_status      = out_st_r;

  `CHM_ASSERT_IMP(a_alloc_bound, clk, rst_n, 1'b1, alloc_r <= CN_W'(NODES), "alloc count past pool")
  `CHM_ASSERT_IMP(a_stack_bound, clk, rst_n, 1'b1, sp_r <= alloc_r, "free stack exceeds allocated nodes")
  `CHM_ASSERT_IMP(a_ins_room, clk, rst_n, cmd.ins, !pool_full, "insert with full pool")
  `CHM_ASSERT_NXT(a_out_load, clk, rst_n, cmd.out_load, out_valid_r, "result load lost")

endmodule

`default_nettype wire

[design/chained_hash_map.sv]
// A BUCKETS count that is not a power of two adds a key division before the bucket read.
// One item is in flight at a time; the next transfer is taken the cycle after the
// result is loaded into the output register, which may still be waiting on out_ready.
// The chain walk visits one node per cycle, with one registered read of the node RAM each.
// Reset sweeps the bucket RAM with in_ready low.
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_map import chm_pkg::*; #(
  parameter int BUCKETS = CHM_BUCKETS,
  parameter int NODES   = CHM_NODES
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_func,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [VAL_W-1:0] in_value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_found,
  output logic      [VAL_W-1:0] out_found_value,
  output logic      [1:0]       out_status
);

  // Command and status groups between sequencer and datapath
  chm_cmd_t  cmd;
  chm_stat_t st;

  // Sequence each transfer: hash the key, read the bucket head, then either
  // push a node, walk the chain one node per cycle, or sweep all buckets.
  chm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Hold the bucket, node and free-stack RAMs plus the result registers.
  // Freed nodes go onto a stack; fresh nodes come from a fill count, so
  // clear only has to reset two counters besides the bucket sweep.
  chm_dp #(
    .BUCKETS (BUCKETS),
    .NODES   (NODES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_found_value (out_found_value),
    .out_status      (out_status),
    .cmd             (cmd),
    .st              (st)
  );

endmodule

`default_nettype wire

[test/tb_chained_hash_map.sv]
// Self-checking testbench of the chained hash map: directed table, then random traffic
`timescale 1ns / 1ps
`default_nettype none

module tb_chained_hash_map import chm_pkg::*; ();

  // One result as the block reports it
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] fval;
    rstat_t           status;
  } lookup_t;

  // One row of the directed table; typed rows carry a hand-written result
  typedef struct {
    func_t            func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    bit               typed;
    lookup_t          res;
  } op_row_t;

  localparam lookup_t R_OK   = '{1'b0, 16'd0, RS_OK};
  localparam lookup_t R_MISS = '{1'b0, 16'd0, RS_MISS};
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam int HOLD_CYCLES = 300;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_func = FN_INSERT;
  logic [KEY_W-1:0] in_key = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_found;
  logic [VAL_W-1:0] out_found_value;
  logic [1:0]       out_status;

  chained_hash_map dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_found(out_found), .out_found_value(out_found_value), .out_status(out_status)
  );

  // Shadow copy of the table state
  logic [8:0]       bkt_head  [CHM_BUCKETS];
  bit               bkt_valid [CHM_BUCKETS];
  logic [KEY_W-1:0] nd_key    [CHM_NODES];
  logic [VAL_W-1:0] nd_value  [CHM_NODES];
  logic [8:0]       nd_next   [CHM_NODES];
  bit               nd_nvalid [CHM_NODES];
  bit               nd_used   [CHM_NODES];

  lookup_t pending_q[$];
  int      errors = 0;
  int      snd_idle = 0;
  int      rcv_idle = 0;
  int      hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run no matter what the block does
  initial begin
    #5ms;
    $display("[chained_hash_map] ERROR");
    $finish;
  end

  function automatic void wipe_table();
    for (int i = 0; i < CHM_BUCKETS; i++) begin
      bkt_head[i] = '0;
      bkt_valid[i] = 1'b0;
    end
    for (int i = 0; i < CHM_NODES; i++) begin
      nd_key[i] = '0;
      nd_value[i] = '0;
      nd_next[i] = '0;
      nd_nvalid[i] = 1'b0;
      nd_used[i] = 1'b0;
    end
  endfunction

  // Follow a chain looking for key; report the node and its predecessor
  function automatic bit chain_search(input int b, input logic [KEY_W-1:0] k,
                                      output int idx, output int prv, output bit has_prv);
    bit ok;
    int cur;
    int steps;
    ok = bkt_valid[b];
    cur = bkt_head[b];
    steps = 0;
    idx = 0;
    prv = 0;
    has_prv = 1'b0;
    while (ok && cur < CHM_NODES && steps < CHM_NODES) begin
      if (nd_key[cur] == k) begin
        idx = cur;
        return 1'b1;
      end
      prv = cur;
      has_prv = 1'b1;
      ok = nd_nvalid[cur];
      cur = nd_next[cur];
      steps++;
    end
    return 1'b0;
  endfunction

  // Apply one operation to the shadow table and return what the block must answer
  function automatic lookup_t apply_op(input func_t f, input logic [KEY_W-1:0] k,
                                       input logic [VAL_W-1:0] v);
    int b;
    int idx;
    int prv;
    int slot;
    bit has_prv;
    b = k % CHM_BUCKETS;
    case (f)
      FN_INSERT: begin
        slot = -1;
        for (int i = 0; i < CHM_NODES; i++)
          if (!nd_used[i] && slot < 0) slot = i;
        if (slot < 0) return '{1'b0, 16'd0, RS_FULL};
        nd_used[slot] = 1'b1;
        nd_key[slot] = k;
        nd_value[slot] = v;
        nd_next[slot] = bkt_head[b];
        nd_nvalid[slot] = bkt_valid[b];
        bkt_head[b] = slot[8:0];
        bkt_valid[b] = 1'b1;
        return R_OK;
      end
      FN_FIND: begin
        if (chain_search(b, k, idx, prv, has_prv)) return '{1'b1, nd_value[idx], RS_OK};
        return R_MISS;
      end
      FN_REMOVE: begin
        if (!chain_search(b, k, idx, prv, has_prv)) return R_MISS;
        if (has_prv) begin
          nd_next[prv] = nd_next[idx];
          nd_nvalid[prv] = nd_nvalid[idx];
        end else begin
          bkt_head[b] = nd_next[idx];
          bkt_valid[b] = nd_nvalid[idx];
        end
        nd_used[idx] = 1'b0;
        return '{1'b1, nd_value[idx], RS_OK};
      end
      default: begin
        wipe_table();
        return R_OK;
      end
    endcase
  endfunction

  // Offer one item, with random idle cycles first, and hold it until transfer
  task automatic offer(input func_t f, input logic [KEY_W-1:0] k,
                       input logic [VAL_W-1:0] v, input bit typed, input lookup_t res);
    lookup_t pred;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      in_func <= 2'($urandom_range(0, 3));
      in_key <= KEY_W'($urandom);
      in_value <= VAL_W'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_key <= k;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    pred = apply_op(f, k, v);
    pending_q.push_back(typed ? res : pred);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Mostly keys that pile into three buckets, sometimes anything at all
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 8)
      return KEY_W'($urandom_range(0, 5) * CHM_BUCKETS + $urandom_range(0, 2));
    return KEY_W'($urandom);
  endfunction

  task automatic random_run(input int n, input int ins_pct);
    int r;
    func_t f;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) f = FN_INSERT;
      else if (r == 99) f = FN_CLEAR;
      else if (r[0]) f = FN_FIND;
      else f = FN_REMOVE;
      offer(f, pick_key(), VAL_W'($urandom), 1'b0, R_OK);
    end
  endtask

  // Result side: check every transfer, then decide next cycle's ready
  initial begin
    lookup_t want;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: result with nothing expected: found %0d value %0d status %0d",
                   $time, out_found, out_found_value, out_status);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (out_found !== want.found) begin
            $display("%0t: found expected %0d got %0d", $time, want.found, out_found);
            errors++;
          end
          if (out_found_value !== want.fval) begin
            $display("%0t: found_value expected %0d got %0d", $time, want.fval,
                     out_found_value);
            errors++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  op_row_t dir_tbl[$];

  initial begin
    // After reset: empty table, then extremes, duplicates, mid-chain unlink, clear
    dir_tbl = '{
      '{FN_FIND,   KEY_MAX,   16'd0,     1, R_MISS},
      '{FN_REMOVE, 22'd0,     16'd0,     1, R_MISS},
      '{FN_INSERT, KEY_MAX,   16'hFFFF,  1, R_OK},
      '{FN_FIND,   KEY_MAX,   16'd0,     1, '{1'b1, 16'hFFFF, RS_OK}},
      '{FN_INSERT, KEY_MAX,   16'd0,     1, R_OK},
      '{FN_FIND,   KEY_MAX,   16'd0,     1, '{1'b1, 16'd0, RS_OK}},
      '{FN_REMOVE, KEY_MAX,   16'd7,     1, '{1'b1, 16'd0, RS_OK}},
      '{FN_FIND,   KEY_MAX,   16'd0,     1, '{1'b1, 16'hFFFF, RS_OK}},
      '{FN_INSERT, 22'd0,     16'd1,     1, R_OK},
      '{FN_INSERT, 22'd1024,  16'd2,     1, R_OK},
      '{FN_INSERT, 22'd2048,  16'h5A5A,  1, R_OK},
      '{FN_REMOVE, 22'd1024,  16'd0,     0, R_OK},
      '{FN_FIND,   22'd0,     16'd0,     0, R_OK},
      '{FN_FIND,   22'd1024,  16'd0,     1, R_MISS},
      '{FN_REMOVE, 22'd0,     16'd0,     0, R_OK},
      '{FN_FIND,   22'd2048,  16'd0,     0, R_OK},
      '{FN_INSERT, 22'h2AAAAA, 16'hAAAA, 0, R_OK},
      '{FN_INSERT, 22'h155555, 16'h5555, 0, R_OK},
      '{FN_CLEAR,  22'd0,     16'd0,     1, R_OK},
      '{FN_FIND,   KEY_MAX,   16'd0,     1, R_MISS},
      '{FN_FIND,   22'd2048,  16'd0,     1, R_MISS}
    };
    wipe_table();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i])
      offer(dir_tbl[i].func, dir_tbl[i].key, dir_tbl[i].value, dir_tbl[i].typed,
            dir_tbl[i].res);

    // No idling on either side
    random_run(50, 40);
    // Sender idles about half the time
    snd_idle = 52;
    random_run(50, 40);
    // Long receiver hold-off while items keep coming, then a stalling receiver
    snd_idle = 0;
    hold_left = HOLD_CYCLES;
    rcv_idle = 52;
    random_run(50, 40);
    // Pause until the table has answered everything, then fill the pool past full
    wait_drained();
    snd_idle = 29;
    rcv_idle = 29;
    offer(FN_CLEAR, KEY_W'($urandom), VAL_W'($urandom), 1'b0, R_OK);
    for (int i = 0; i < CHM_NODES + 6; i++)
      offer(FN_INSERT, pick_key(), VAL_W'($urandom), 1'b0, R_OK);
    // Free some nodes and reuse them
    random_run(40, 30);

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("[chained_hash_map] OK");
    end else begin
      $display("[chained_hash_map] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+design
design/chm_pkg.sv
design/chm_ram.sv
design/chm_ctrl.sv
design/chm_dp.sv
design/chained_hash_map.sv
test/tb_chained_hash_map.sv
